[sv/mdpq_pkg.sv]
// ----------------------------------------------------------------------------
// mdpq_pkg
// shared types, constants and channel conversion functions
// ----------------------------------------------------------------------------
package mdpq_pkg;

    localparam int PALETTE_ENTRIES = 16;
    localparam int COLOR_KEY_BITS  = 15;
    localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
    localparam int CNT_W           = $clog2(PALETTE_ENTRIES + 1);
    localparam int KEY_DEPTH       = 1 << COLOR_KEY_BITS;
    localparam int DIST_W          = 10;
    localparam logic [7:0] THRESHOLD_RESET = 8'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LOOKUP,
        ST_SEARCH,
        ST_DECIDE,
        ST_OUTPUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture vote result, start decision read
        logic clr_step;    // clear one decision entry
        logic search_start;
        logic search_step;
        logic commit;      // apply decision, write back
        logic out_load;    // publish result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic hit;
        logic search_done;
    } t_status;

    // c * 31 / 255 for 8-bit c
    function automatic logic [4:0] to5(input logic [7:0] c);
        logic [12:0] p;
        logic [21:0] q;
        p = {5'd0, c} * 13'd31;
        q = ({9'd0, p} + 22'd1) * 22'd257;
        return q[20:16];
    endfunction

    // v * 255 / 31 for 5-bit v, constant table
    function automatic logic [7:0] to8(input logic [4:0] v);
        logic [7:0] r;
        case (v)
            5'd0: r = 8'd0;     5'd1: r = 8'd8;     5'd2: r = 8'd16;   5'd3: r = 8'd24;
            5'd4: r = 8'd32;    5'd5: r = 8'd41;    5'd6: r = 8'd49;   5'd7: r = 8'd57;
            5'd8: r = 8'd65;    5'd9: r = 8'd74;    5'd10: r = 8'd82;  5'd11: r = 8'd90;
            5'd12: r = 8'd98;   5'd13: r = 8'd106;  5'd14: r = 8'd115; 5'd15: r = 8'd123;
            5'd16: r = 8'd131;  5'd17: r = 8'd139;  5'd18: r = 8'd148; 5'd19: r = 8'd156;
            5'd20: r = 8'd164;  5'd21: r = 8'd172;  5'd22: r = 8'd180; 5'd23: r = 8'd189;
            5'd24: r = 8'd197;  5'd25: r = 8'd205;  5'd26: r = 8'd213; 5'd27: r = 8'd222;
            5'd28: r = 8'd230;  5'd29: r = 8'd238;  5'd30: r = 8'd246;
            default: r = 8'd255;
        endcase
        return r;
    endfunction

endpackage

[sv/mdpq_ctrl.sv]
// ----------------------------------------------------------------------------
// mdpq_ctrl
// sequencer: decision memory clear, lookup, palette search, commit, output
// ----------------------------------------------------------------------------
module mdpq_ctrl import mdpq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:  if (i_status.clr_done) n_state = ST_IDLE;
            ST_IDLE:   if (i_in_valid) n_state = ST_LOOKUP;
            ST_LOOKUP: n_state = i_status.hit ? ST_OUTPUT : ST_SEARCH;
            ST_SEARCH: if (i_status.search_done) n_state = ST_DECIDE;
            ST_DECIDE: n_state = ST_OUTPUT;
            ST_OUTPUT: if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_CLEAR:  o_cmd.clr_step = 1'b1;
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_LOOKUP: o_cmd.search_start = 1'b1;
            ST_SEARCH: o_cmd.search_step = 1'b1;
            ST_DECIDE: o_cmd.commit = 1'b1;
            ST_OUTPUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

[sv/mdpq_dp.sv]
// ----------------------------------------------------------------------------
// mdpq_dp
// vote, color conversion, decision memory, palette and nearest search
// ----------------------------------------------------------------------------
module mdpq_dp import mdpq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic [23:0] i_pixel_top_left,
    input  logic [23:0] i_pixel_top_right,
    input  logic [23:0] i_pixel_bottom_left,
    input  logic [23:0] i_pixel_bottom_right,
    output t_status     o_status,
    output logic [3:0]  o_palette_index,
    output logic        o_entry_added,
    output logic        o_entry_merged,
    output logic [15:0] o_color_word
);

    logic [7:0]  r_thresh;
    logic [15:0] r_word;
    logic [IDX_W-1:0] mem_idx [KEY_DEPTH];
    logic        mem_vld [KEY_DEPTH];
    logic [IDX_W-1:0] r_rd_idx;
    logic        r_rd_vld;
    logic [15:0] r_pal [PALETTE_ENTRIES];
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_p;
    logic [DIST_W-1:0] r_best;
    logic        r_best_inf;
    logic [IDX_W-1:0] r_best_p;
    logic [IDX_W-1:0] r_idx;
    logic        r_added, r_merged;
    logic [COLOR_KEY_BITS:0] r_sweep;

    // majority vote
    logic [23:0] px;
    logic [15:0] word;
    always_comb begin
        if (i_pixel_top_left == i_pixel_top_right || i_pixel_top_left == i_pixel_bottom_left
            || i_pixel_top_left == i_pixel_bottom_right)
            px = i_pixel_top_left;
        else if (i_pixel_top_right == i_pixel_bottom_left
                 || i_pixel_top_right == i_pixel_bottom_right)
            px = i_pixel_top_right;
        else if (i_pixel_bottom_left == i_pixel_bottom_right)
            px = i_pixel_bottom_left;
        else
            px = i_pixel_bottom_right;
        word = {1'b1, to5(px[7:0]), to5(px[15:8]), to5(px[23:16])};
    end

    wire [COLOR_KEY_BITS-1:0] key_in = word[COLOR_KEY_BITS-1:0];
    wire [COLOR_KEY_BITS-1:0] key    = r_word[COLOR_KEY_BITS-1:0];

    // one candidate distance per search cycle
    logic [15:0] cand;
    logic [DIST_W-1:0] cand_dist;
    function automatic logic [7:0] ad(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a - b : b - a;
    endfunction
    always_comb begin
        cand = r_pal[r_p[IDX_W-1:0]];
        cand_dist = DIST_W'(ad(to8(r_word[4:0]), to8(cand[4:0])))
                  + DIST_W'(ad(to8(r_word[9:5]), to8(cand[9:5])))
                  + DIST_W'(ad(to8(r_word[14:10]), to8(cand[14:10])));
    end

    wire search_end = (r_p >= r_cnt) || (r_p >= CNT_W'(PALETTE_ENTRIES));
    wire full       = (r_cnt >= CNT_W'(PALETTE_ENTRIES));
    wire do_merge   = (!r_best_inf && {2'b0, r_thresh} > r_best && r_cnt != '0) || full;

    // decision memory: sweep clear, registered read, write on commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step)
            mem_vld[r_sweep[COLOR_KEY_BITS-1:0]] <= 1'b0;
        else if (i_cmd.commit) begin
            mem_vld[key] <= 1'b1;
            mem_idx[key] <= do_merge ? r_best_p : r_cnt[IDX_W-1:0];
        end
        if (i_cmd.load) begin
            r_rd_vld <= mem_vld[key_in];
            r_rd_idx <= mem_idx[key_in];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep  <= '0;
            r_thresh <= THRESHOLD_RESET;
            r_cnt    <= '0;
            for (int i = 0; i < PALETTE_ENTRIES; i++) r_pal[i] <= '0;
        end else begin
            if (i_cmd.clr_step) r_sweep <= r_sweep + 1'b1;
            if (i_cfg_we) r_thresh <= i_cfg_data;
            if (i_cmd.commit && !do_merge) begin
                r_pal[r_cnt[IDX_W-1:0]] <= r_word;
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_word <= word;
        if (i_cmd.search_start) begin
            r_p        <= CNT_W'(1);
            r_best_inf <= 1'b1;
            r_best_p   <= '0;
            r_best     <= '0;
            r_added    <= 1'b0;
            r_merged   <= 1'b0;
            r_idx      <= r_rd_idx;
        end
        if (i_cmd.search_step && !search_end) begin
            r_p <= r_p + 1'b1;
            if (r_best_inf || cand_dist < r_best) begin
                r_best     <= cand_dist;
                r_best_inf <= 1'b0;
                r_best_p   <= r_p[IDX_W-1:0];
            end
        end
        if (i_cmd.commit) begin
            r_idx    <= do_merge ? r_best_p : r_cnt[IDX_W-1:0];
            r_merged <= do_merge;
            r_added  <= !do_merge;
        end
        if (i_cmd.out_load) begin
            o_palette_index <= 4'(r_idx);
            o_entry_added   <= r_added;
            o_entry_merged  <= r_merged;
            o_color_word    <= r_word;
        end
    end

    assign o_status.clr_done    = r_sweep[COLOR_KEY_BITS]
                                || (r_sweep == {1'b0, {COLOR_KEY_BITS{1'b1}}});
    assign o_status.hit         = r_rd_vld;
    assign o_status.search_done = search_end;

endmodule

[sv/majority_downscale_palette_quantizer_unit.sv]
// ----------------------------------------------------------------------------
// majority_downscale_palette_quantizer_unit
// 2x2 majority downscale with adaptive 16-entry palette
// ----------------------------------------------------------------------------
// After reset the unit sweeps its 32768-entry color decision memory, one
// entry a cycle, before taking the first request. A remembered color then
// goes from the lookup straight to output; a new color first passes the
// nearest-color search over the filled palette entries past entry 0 and
// the decision step. The search tests one palette entry per cycle. The merge
// threshold may be written at any time the unit is idle.
module majority_downscale_palette_quantizer_unit import mdpq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [23:0] i_pixel_top_left,
    input  logic [23:0] i_pixel_top_right,
    input  logic [23:0] i_pixel_bottom_left,
    input  logic [23:0] i_pixel_bottom_right,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_palette_index,
    output logic        o_entry_added,
    output logic        o_entry_merged,
    output logic [15:0] o_color_word
);

    t_cmd    cmd;
    t_status status;

    // sequencer
    mdpq_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .i_status(status), .o_cmd(cmd)
    );

    // vote, conversion, memories and search
    mdpq_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_cfg_we, .i_cfg_data,
        .i_pixel_top_left, .i_pixel_top_right, .i_pixel_bottom_left,
        .i_pixel_bottom_right, .o_status(status), .o_palette_index,
        .o_entry_added, .o_entry_merged, .o_color_word
    );

endmodule

[sv/mdpq_checker.sv]
// ----------------------------------------------------------------------------
// mdpq_checker
// port level checks for the quantizer unit
// ----------------------------------------------------------------------------
module mdpq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_entry_added,
    input logic        o_entry_merged,
    input logic [15:0] o_color_word
);

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_entry_added && o_entry_merged)) else $error("flags");
    a_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_color_word[15]) else $error("bit 15");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_color_word))
        else $error("hold");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready) else $error("busy");

endmodule

bind majority_downscale_palette_quantizer_unit mdpq_checker u_chk (
    .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
    .o_entry_added, .o_entry_merged, .o_color_word
);

[bench/majority_downscale_palette_quantizer_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// majority_downscale_palette_quantizer_unit_tb
// self-checking bench: 2x2 blocks are fed through a valid/ready driver, every
// result is compared against an in-bench palette quantizer that tracks the
// palette, the color decision memory and the merge threshold
// ----------------------------------------------------------------------------
module majority_downscale_palette_quantizer_unit_tb import mdpq_pkg::*; ();

    localparam int WATCHDOG_LIMIT = 200000;  // covers the decision memory sweep
    localparam int SETTLE_CYCLES  = 40;      // longest new-color request plus margin
    localparam int PHASE_ITEMS    = 580;
    localparam int POOL_SIZE      = 40;

    typedef struct packed {
        logic [23:0] tl;
        logic [23:0] tr;
        logic [23:0] bl;
        logic [23:0] br;
    } t_pixel_block;

    typedef struct packed {
        logic [3:0]  index;
        logic        added;
        logic        merged;
        logic [15:0] word;
    } t_quant_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [23:0] i_pixel_top_left = '0;
    logic [23:0] i_pixel_top_right = '0;
    logic [23:0] i_pixel_bottom_left = '0;
    logic [23:0] i_pixel_bottom_right = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [3:0]  o_palette_index;
    logic        o_entry_added;
    logic        o_entry_merged;
    logic [15:0] o_color_word;

    majority_downscale_palette_quantizer_unit uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_pixel_top_left     (i_pixel_top_left),
        .i_pixel_top_right    (i_pixel_top_right),
        .i_pixel_bottom_left  (i_pixel_bottom_left),
        .i_pixel_bottom_right (i_pixel_bottom_right),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_palette_index      (o_palette_index),
        .o_entry_added        (o_entry_added),
        .o_entry_merged       (o_entry_merged),
        .o_color_word         (o_color_word)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // quantizer state mirrored in the bench
    // ------------------------------------------------------------------
    logic [15:0] palette_colors [PALETTE_ENTRIES];
    int          palette_count;
    bit          decision_valid [KEY_DEPTH];
    logic [3:0]  decision_index [KEY_DEPTH];
    logic [7:0]  merge_threshold;

    t_pixel_block  pending_blocks[$];
    t_quant_result expected_results[$];
    logic [23:0]   color_pool [POOL_SIZE];

    int error_count = 0;
    int accept_count = 0;
    int driven_count = 0;
    int idle_cycles = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // 8-bit channel down to 5 bits, truncating divide
    function automatic int chan_to5(input logic [7:0] c);
        return (int'(c) * 31) / 255;
    endfunction

    // 5-bit channel back up to 0..255
    function automatic int chan_to8(input logic [4:0] v);
        return (int'(v) * 255) / 31;
    endfunction

    function automatic int channel_gap(input logic [4:0] a, input logic [4:0] b);
        int x;
        int y;
        x = chan_to8(a);
        y = chan_to8(b);
        return (x > y) ? x - y : y - x;
    endfunction

    // summed channel distance of two color words
    function automatic int word_distance(input logic [15:0] a, input logic [15:0] b);
        return channel_gap(a[4:0], b[4:0]) + channel_gap(a[9:5], b[9:5])
             + channel_gap(a[14:10], b[14:10]);
    endfunction

    // majority pick: first pixel matching a later one, else bottom right
    function automatic logic [23:0] vote_pixel(input t_pixel_block b);
        if (b.tl == b.tr || b.tl == b.bl || b.tl == b.br) return b.tl;
        if (b.tr == b.bl || b.tr == b.br) return b.tr;
        if (b.bl == b.br) return b.bl;
        return b.br;
    endfunction

    // full per-request prediction, updates palette and decision memory
    task automatic quantize_block(input t_pixel_block b);
        logic [23:0]   px;
        logic [14:0]   key;
        int            best;
        int            best_p;
        int            d;
        t_quant_result r;
        px = vote_pixel(b);
        r.word = {1'b1, 5'(chan_to5(px[7:0])), 5'(chan_to5(px[15:8])),
                  5'(chan_to5(px[23:16]))};
        key = r.word[14:0];
        r.added = 1'b0;
        r.merged = 1'b0;
        if (decision_valid[key]) begin
            r.index = decision_index[key];
        end else begin
            best = 'hFFFF;
            best_p = 0;
            // entry 0 never takes part in the search, ties keep the lowest entry
            for (int p = 1; p < palette_count && p < PALETTE_ENTRIES; p++) begin
                d = word_distance(r.word, palette_colors[p]);
                if (d < best) begin
                    best = d;
                    best_p = p;
                end
            end
            if ((best < int'(merge_threshold) && palette_count != 0) ||
                palette_count >= PALETTE_ENTRIES) begin
                r.index = 4'(best_p);
                r.merged = 1'b1;
            end else begin
                r.index = 4'(palette_count);
                palette_colors[palette_count] = r.word;
                palette_count++;
                r.added = 1'b1;
            end
            decision_valid[key] = 1'b1;
            decision_index[key] = r.index;
        end
        expected_results.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // request driver: changes inputs at the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
            // hold the request until the monitor has seen it accepted
            if (!(i_in_valid && accept_count != driven_count)) begin
                if (pending_blocks.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    i_in_valid           <= 1'b1;
                    i_pixel_top_left     <= pending_blocks[0].tl;
                    i_pixel_top_right    <= pending_blocks[0].tr;
                    i_pixel_bottom_left  <= pending_blocks[0].bl;
                    i_pixel_bottom_right <= pending_blocks[0].br;
                    void'(pending_blocks.pop_front());
                    driven_count <= driven_count + 1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: predicts on accepted requests, checks accepted results
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                quantize_block({i_pixel_top_left, i_pixel_top_right,
                                i_pixel_bottom_left, i_pixel_bottom_right});
                accept_count <= accept_count + 1;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: palette_index %0d color_word %h",
                           o_palette_index, o_color_word);
                    error_count++;
                end else begin
                    if (o_palette_index !== expected_results[0].index) begin
                        $error("palette_index expected %0d actual %0d",
                               expected_results[0].index, o_palette_index);
                        error_count++;
                    end
                    if (o_entry_added !== expected_results[0].added) begin
                        $error("entry_added expected %0d actual %0d",
                               expected_results[0].added, o_entry_added);
                        error_count++;
                    end
                    if (o_entry_merged !== expected_results[0].merged) begin
                        $error("entry_merged expected %0d actual %0d",
                               expected_results[0].merged, o_entry_merged);
                        error_count++;
                    end
                    if (o_color_word !== expected_results[0].word) begin
                        $error("color_word expected %h actual %h",
                               expected_results[0].word, o_color_word);
                        error_count++;
                    end
                    void'(expected_results.pop_front());
                end
            end
            // watchdog on cycles with no handshake on either side
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [23:0] pick_color();
        if ($urandom_range(1) == 0) return color_pool[$urandom_range(POOL_SIZE - 1)];
        return 24'($urandom);
    endfunction

    // one block with a random vote pattern
    function automatic t_pixel_block random_block();
        t_pixel_block b;
        logic [23:0]  c;
        c = pick_color();
        b = {24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom)};
        case ($urandom_range(7))
            0: b.tr = c;
            1: b.bl = c;
            2: b.br = c;
            3: begin b.tr = c; b.bl = c; end
            4: b.bl = b.tr;
            5: b.br = b.tr;
            6: b.br = b.bl;
            default: b.br = c;   // bottom right wins unless tl also takes c
        endcase
        if ($urandom_range(2) != 0) b.tl = c;
        return b;
    endfunction

    task automatic queue_same(input logic [23:0] c);
        pending_blocks.push_back({c, c, c, c});
    endtask

    // wait for every request to be answered, then let the unit settle
    task automatic drain();
        while (pending_blocks.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [7:0] thr);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= thr;
        merge_threshold = thr;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input logic [7:0] thr, input int tx, input int rx);
        write_threshold(thr);
        tx_idle_pct = tx;
        rx_idle_pct = rx;
        for (int n = 0; n < PHASE_ITEMS; n++) pending_blocks.push_back(random_block());
        drain();
    endtask

    initial begin
        for (int i = 0; i < PALETTE_ENTRIES; i++) palette_colors[i] = '0;
        palette_count = 0;
        merge_threshold = THRESHOLD_RESET;
        for (int i = 0; i < POOL_SIZE; i++) color_pool[i] = 24'($urandom);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset threshold
        tx_idle_pct = 14;
        rx_idle_pct = 75;
        queue_same(24'h000000);                  // empty palette, appended
        queue_same(24'hFFFFFF);                  // single entry, no candidate
        queue_same(24'hF7FFFF);                  // red one step off white, merges
        queue_same(24'hFFFFFF);                  // remembered color
        pending_blocks.push_back({24'h102030, 24'h102030, 24'h405060, 24'h708090});
        pending_blocks.push_back({24'h112233, 24'h445566, 24'h112233, 24'h778899});
        pending_blocks.push_back({24'hA0B0C0, 24'h123456, 24'h654321, 24'hA0B0C0});
        pending_blocks.push_back({24'h010203, 24'h3C3C3C, 24'h3C3C3C, 24'h040506});
        pending_blocks.push_back({24'h0A0B0C, 24'h5A5A00, 24'h0D0E0F, 24'h5A5A00});
        pending_blocks.push_back({24'h111111, 24'h222222, 24'h00FF00, 24'h00FF00});
        pending_blocks.push_back({24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h808080});
        queue_same(24'hFF0000);
        queue_same(24'h0000FF);
        queue_same(24'h00FFFF);
        queue_same(24'hFFFF00);
        queue_same(24'hFF00FF);
        queue_same(24'h408040);
        queue_same(24'h804080);
        queue_same(24'hC0C0C0);
        queue_same(24'h202020);                  // full palette, merges
        queue_same(24'h5555AA);                  // full palette, merges
        queue_same(24'h0000FF);                  // remembered after fill
        drain();

        // random phases: threshold extremes and a random one
        random_phase(8'd255, 14, 75);
        random_phase(8'd0, 75, 14);
        random_phase(8'($urandom), 0, 0);

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
